// ===== sv/block_direct_mapped_cache_macros.svh =====
// Assertion macros shared by the block cache tag controller.
`ifndef BLOCK_DIRECT_MAPPED_CACHE_MACROS_SVH
`define BLOCK_DIRECT_MAPPED_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bdmc_pkg.sv =====
// Package: types, widths and codes of the block cache tag controller.
package bdmc_pkg;

  localparam int SLOT_COUNT_DEF = 128;
  localparam int BLOCK_W        = 32;
  localparam int DISK_W         = 33;
  localparam int SLOT_W         = 7;
  localparam int KIND_W         = 2;
  localparam int DATA_W         = 32;
  localparam int PADDR_W        = 3;
  localparam int REG_DATA_START = 0;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT  = 2'd0,
    KIND_FILL = 2'd1,
    KIND_WB   = 2'd2
  } kind_e;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic  emit;
    logic  last;
    kind_e kind;
    logic  write_en;
    logic  write_valid;
  } step_t;

endpackage

// ===== sv/bdmc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bdmc_tag_store.sv =====
// Tag store: tag memory with valid flag, clearing pass after reset and write forwarding.
module bdmc_tag_store #(
  parameter int SLOT_COUNT = bdmc_pkg::SLOT_COUNT_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         rd_en_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]                rd_addr_i,
  input  logic                                         wr_en_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]                wr_addr_i,
  input  logic                                         wr_valid_i,
  input  logic [bdmc_pkg::BLOCK_W-$clog2(SLOT_COUNT)-1:0] wr_tag_i,
  output logic                                         entry_valid_o,
  output logic [bdmc_pkg::BLOCK_W-$clog2(SLOT_COUNT)-1:0] entry_tag_o,
  output logic                                         clearing_o
);
  import bdmc_pkg::*;

  localparam int AddrBits  = $clog2(SLOT_COUNT);
  localparam int TagBits   = BLOCK_W - AddrBits;
  localparam int EntryBits = TagBits + 1;

  logic                 clearing_q, clearing_d;
  logic [AddrBits-1:0]  clr_idx_q, clr_idx_d;
  logic                 ram_we;
  logic [AddrBits-1:0]  ram_waddr;
  logic [EntryBits-1:0] ram_wdata;
  logic [EntryBits-1:0] ram_rdata;
  logic [AddrBits-1:0]  raddr_q;
  logic                 fwd_valid_q;
  logic [AddrBits-1:0]  fwd_addr_q;
  logic [EntryBits-1:0] fwd_data_q;
  logic [EntryBits-1:0] entry;

  // The clearing pass owns the write port until every entry has been invalidated.
  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + AddrBits'(1);
      if (clr_idx_q == AddrBits'(SLOT_COUNT - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_en_i;
      ram_waddr = wr_addr_i;
      ram_wdata = {wr_valid_i, wr_tag_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_idx_q   <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
      if (ram_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // The most recent write is kept aside; a read that raced it takes this copy instead.
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= ram_waddr;
      fwd_data_q <= ram_wdata;
    end
    if (rd_en_i) begin
      raddr_q <= rd_addr_i;
    end
  end

  bdmc_ram #(
    .WIDTH (EntryBits),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  assign entry         = (fwd_valid_q && (fwd_addr_q == raddr_q)) ? fwd_data_q : ram_rdata;
  assign entry_valid_o = entry[EntryBits-1];
  assign entry_tag_o   = entry[TagBits-1:0];
  assign clearing_o    = clearing_q;

endmodule

// ===== sv/bdmc_resolve.sv =====
// Resolve: decides the result of a lookup or flush from the slot entry.
module bdmc_resolve #(
  parameter int SLOT_COUNT = bdmc_pkg::SLOT_COUNT_DEF
) (
  input  bdmc_pkg::cmd_e                                cmd_i,
  input  logic [bdmc_pkg::BLOCK_W-1:0]                  block_number_i,
  input  logic [bdmc_pkg::SLOT_W-1:0]                   flush_slot_i,
  input  logic                                          phase_i,
  input  logic [bdmc_pkg::DATA_W-1:0]                   start_i,
  input  logic                                          entry_valid_i,
  input  logic [bdmc_pkg::BLOCK_W-$clog2(SLOT_COUNT)-1:0] entry_tag_i,
  output bdmc_pkg::step_t                               step_o,
  output logic [bdmc_pkg::DISK_W-1:0]                   disk_block_o,
  output logic [$clog2(SLOT_COUNT)-1:0]                 slot_idx_o,
  output logic [bdmc_pkg::SLOT_W-1:0]                   slot_field_o
);
  import bdmc_pkg::*;

  localparam int AddrBits = $clog2(SLOT_COUNT);
  localparam int TagBits  = BLOCK_W - AddrBits;

  logic [BLOCK_W-1:0]  fs_ext;
  logic [BLOCK_W-1:0]  idx_ext;
  logic                flush_ok;
  logic [AddrBits-1:0] idx;
  logic [TagBits-1:0]  req_tag;
  logic                tag_match;
  logic [DISK_W-1:0]   req_addr;
  logic [DISK_W-1:0]   res_addr;
  logic                use_resident;

  assign fs_ext    = BLOCK_W'(flush_slot_i);
  assign flush_ok  = fs_ext < BLOCK_W'(SLOT_COUNT);
  assign req_tag   = block_number_i[BLOCK_W-1:AddrBits];
  assign tag_match = entry_valid_i && (entry_tag_i == req_tag);

  always_comb begin
    case (cmd_i)
      CMD_FLUSH: idx = fs_ext[AddrBits-1:0];
      default:   idx = block_number_i[AddrBits-1:0];
    endcase
  end

  // The resident block number is the stored tag with the slot index below it.
  assign req_addr = DISK_W'(start_i) + DISK_W'(block_number_i);
  assign res_addr = DISK_W'(start_i) + DISK_W'({entry_tag_i, idx});

  always_comb begin
    step_o       = '0;
    use_resident = 1'b0;
    case (cmd_i)
      CMD_FLUSH: begin
        step_o.emit        = flush_ok && entry_valid_i;
        step_o.last        = 1'b1;
        step_o.kind        = KIND_WB;
        step_o.write_en    = flush_ok && entry_valid_i;
        step_o.write_valid = 1'b0;
        use_resident       = 1'b1;
      end
      default: begin
        step_o.emit        = 1'b1;
        step_o.write_en    = !tag_match;
        step_o.write_valid = 1'b1;
        if (!phase_i && entry_valid_i && !tag_match) begin
          // Conflict: the resident block goes back to disk before the fill.
          step_o.kind  = KIND_WB;
          step_o.last  = 1'b0;
          use_resident = 1'b1;
        end else if (!phase_i && tag_match) begin
          step_o.kind = KIND_HIT;
          step_o.last = 1'b1;
        end else begin
          step_o.kind = KIND_FILL;
          step_o.last = 1'b1;
        end
      end
    endcase
  end

  assign idx_ext      = BLOCK_W'(idx);
  assign disk_block_o = use_resident ? res_addr : req_addr;
  assign slot_idx_o   = idx;
  assign slot_field_o = idx_ext[SLOT_W-1:0];

endmodule

// ===== sv/block_direct_mapped_cache.sv =====
// Top level: tag controller of a direct-mapped disk block cache.
// A word accepted into the resolve stage has its first result loaded into the output register
// once that register is free. Hits, fills and flushes go at one word per cycle while the output
// register is not held by out_ready_i; a conflict holds the resolve stage until the single output
// register has carried both its results. Reset: rst_ni clears control state at once, then a
// clearing pass writes every slot of the tag memory invalid, one slot a cycle, accepting no word.
`include "block_direct_mapped_cache_macros.svh"

module block_direct_mapped_cache #(
  parameter int SLOT_COUNT = bdmc_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB-style configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bdmc_pkg::PADDR_W-1:0]    paddr,
  input  logic [bdmc_pkg::DATA_W-1:0]     pwdata,
  output logic [bdmc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // Request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [bdmc_pkg::BLOCK_W-1:0]    block_number_i,
  input  logic [bdmc_pkg::SLOT_W-1:0]     flush_slot_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bdmc_pkg::KIND_W-1:0]     kind_o,
  output logic [bdmc_pkg::DISK_W-1:0]     disk_block_o,
  output logic [bdmc_pkg::SLOT_W-1:0]     slot_o,
  output logic                            last_o
);
  import bdmc_pkg::*;

  // The slot index is the low bits of the block number, so SLOT_COUNT must be a power of two (not enforced here).
  localparam int AddrBits = $clog2(SLOT_COUNT);
  localparam int TagBits  = BLOCK_W - AddrBits;

  // Configuration register.
  logic [DATA_W-1:0] start_q;
  logic              cfg_sel;
  logic              cfg_write;

  assign cfg_sel   = paddr[PADDR_W-1:2] == 1'(REG_DATA_START);
  assign cfg_write = psel && penable && pwrite && cfg_sel;
  assign pready    = 1'b1;
  assign prdata    = cfg_sel ? start_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_write) begin
      start_q <= pwdata;
    end
  end

  // Resolve stage: the accepted word waits here while its tag entry is read.
  logic                s1_valid_q, s1_valid_d;
  cmd_e                s1_cmd_q;
  logic [BLOCK_W-1:0]  s1_bno_q;
  logic [SLOT_W-1:0]   s1_fslot_q;
  logic                phase_q, phase_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q;
  logic [DISK_W-1:0]   out_blk_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_last_q;

  logic                clearing;
  logic                entry_valid;
  logic [TagBits-1:0]  entry_tag;
  step_t               step;
  logic [DISK_W-1:0]   step_blk;
  logic [AddrBits-1:0] step_idx;
  logic [SLOT_W-1:0]   step_slot;
  logic                out_free;
  logic                load_out;
  logic                retire;
  logic                accept;
  logic [BLOCK_W-1:0]  in_fs_ext;
  logic [AddrBits-1:0] rd_addr;

  // The output register is free when empty or when its result is taken in this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = s1_valid_q && step.emit && out_free;
  // A word leaves the resolve stage with its final result, or at once when it has none.
  assign retire   = s1_valid_q && (!step.emit || (out_free && step.last));
  assign in_ready_o = !clearing && (!s1_valid_q || retire);
  assign accept   = in_valid_i && in_ready_o;

  // The tag entry is read as the word is accepted, so it is ready in the resolve stage.
  assign in_fs_ext = BLOCK_W'(flush_slot_i);
  always_comb begin
    case (cmd_e'(cmd_i))
      CMD_FLUSH: rd_addr = in_fs_ext[AddrBits-1:0];
      default:   rd_addr = block_number_i[AddrBits-1:0];
    endcase
  end

  bdmc_tag_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_tag_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (accept),
    .rd_addr_i     (rd_addr),
    .wr_en_i       (retire && step.write_en),
    .wr_addr_i     (step_idx),
    .wr_valid_i    (step.write_valid),
    .wr_tag_i      (s1_bno_q[BLOCK_W-1:AddrBits]),
    .entry_valid_o (entry_valid),
    .entry_tag_o   (entry_tag),
    .clearing_o    (clearing)
  );

  bdmc_resolve #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_resolve (
    .cmd_i          (s1_cmd_q),
    .block_number_i (s1_bno_q),
    .flush_slot_i   (s1_fslot_q),
    .phase_i        (phase_q),
    .start_i        (start_q),
    .entry_valid_i  (entry_valid),
    .entry_tag_i    (entry_tag),
    .step_o         (step),
    .disk_block_o   (step_blk),
    .slot_idx_o     (step_idx),
    .slot_field_o   (step_slot)
  );

  // Control next state: the phase marks that a conflict's write-back has gone out.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (retire) begin
      s1_valid_d = 1'b0;
    end

    phase_d = phase_q;
    if (retire) begin
      phase_d = 1'b0;
    end else if (load_out) begin
      phase_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= cmd_e'(cmd_i);
      s1_bno_q   <= block_number_i;
      s1_fslot_q <= flush_slot_i;
    end
    if (load_out) begin
      out_kind_q <= step.kind;
      out_blk_q  <= step_blk;
      out_slot_q <= step_slot;
      out_last_q <= step.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign disk_block_o = out_blk_q;
  assign slot_o       = out_slot_q;
  assign last_o       = out_last_q;

  `BDMC_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, clearing, !in_ready_o, "word accepted during clearing pass")
  `BDMC_ASSERT_NOW(a_phase_has_word, clk_i, rst_ni, phase_q, s1_valid_q, "second phase without a word in the resolve stage")
  `BDMC_ASSERT_NOW(a_hit_is_last, clk_i, rst_ni, out_valid_q && (out_kind_q == KIND_HIT), out_last_q, "hit result not marked last")
  `BDMC_ASSERT_NEXT(a_wb_then_fill, clk_i, rst_ni, out_valid_q && out_ready_i && (out_kind_q == KIND_WB) && !out_last_q, out_valid_q && (out_kind_q == KIND_FILL) && out_last_q, "conflict write-back not followed by its fill")

endmodule
